FILE: design/fsa_pkg.sv
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared types and constants for the Fubini-Study angle block.
// ----------------------------------------------------------------------------
package fsa_pkg;

    localparam int AccW       = 44;
    localparam int MaxLength  = 4096;
    localparam int CntW       = 13;
    localparam int CordicN    = 18;
    localparam int ZW         = 22;
    localparam logic [15:0] AngleMax = 16'd51472;

    typedef struct packed {
        logic signed [15:0] v_real;
        logic signed [15:0] v_imag;
        logic signed [15:0] w_real;
        logic signed [15:0] w_imag;
        logic               last;
    } t_in_word;

    typedef struct packed {
        logic [15:0] angle;
        logic        degenerate;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_ACC,
        ST_MUL,
        ST_DIV,
        ST_SQRT_C,
        ST_SQRT_S,
        ST_CORDIC,
        ST_OUT
    } t_state;

    // arctangent of 2^-i in Q.20
    function automatic logic [ZW-1:0] atan_q20(input logic [4:0] idx);
        case (idx)
            5'd0:  atan_q20 = 22'd823550;
            5'd1:  atan_q20 = 22'd486170;
            5'd2:  atan_q20 = 22'd256879;
            5'd3:  atan_q20 = 22'd130396;
            5'd4:  atan_q20 = 22'd65451;
            5'd5:  atan_q20 = 22'd32757;
            5'd6:  atan_q20 = 22'd16383;
            5'd7:  atan_q20 = 22'd8192;
            5'd8:  atan_q20 = 22'd4096;
            5'd9:  atan_q20 = 22'd2048;
            5'd10: atan_q20 = 22'd1024;
            5'd11: atan_q20 = 22'd512;
            5'd12: atan_q20 = 22'd256;
            5'd13: atan_q20 = 22'd128;
            5'd14: atan_q20 = 22'd64;
            5'd15: atan_q20 = 22'd32;
            5'd16: atan_q20 = 22'd16;
            5'd17: atan_q20 = 22'd8;
            default: atan_q20 = '0;
        endcase
    endfunction

endpackage

FILE: design/fsa_mul.sv
// ----------------------------------------------------------------------------
// fsa_mul
// Shared 44x44 unsigned multiplier, 22x22 partial products, one per cycle.
// ----------------------------------------------------------------------------
module fsa_mul
    import fsa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [AccW-1:0]      i_a,
    input  logic [AccW-1:0]      i_b,
    output logic                 o_done,
    output logic [2*AccW-1:0]    o_p
);
    localparam int HW = AccW / 2;

    logic [AccW-1:0]   r_a, r_b;
    logic [2:0]        r_step;
    logic              r_busy;
    logic [2*AccW-1:0] r_p;
    logic [HW-1:0]     w_x, w_y;
    logic [2*HW-1:0]   w_pp;
    logic [2*AccW-1:0] w_sh;

    // pick halves for this step
    always_comb begin
        w_x  = r_step[1] ? r_a[AccW-1:HW] : r_a[HW-1:0];
        w_y  = r_step[0] ? r_b[AccW-1:HW] : r_b[HW-1:0];
        w_pp = w_x * w_y;
        w_sh = {{(2*AccW-2*HW){1'b0}}, w_pp}
               << (HW * ({1'b0, r_step[1]} + {1'b0, r_step[0]}));
    end

    // accumulate four partial products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_p    <= '0;
            end else if (r_busy) begin
                r_p    <= r_p + w_sh;
                r_step <= r_step + 3'd1;
                if (r_step == 3'd3) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_p = r_p;
endmodule

FILE: design/fubini_study_angle.sv
// ----------------------------------------------------------------------------
// fubini_study_angle
// Streams complex element pairs, accumulates <v,w>, |v|^2 and |w|^2, and on
// the last pair emits arccos(|<v,w>|/(|v||w|)) in Q2.14 radians.
// ----------------------------------------------------------------------------
// Non-last words are taken one per cycle while no result is waiting. A last
// word starts the finishing sequence on one shared multiplier and
// shift-subtract unit: three 44x44 products, a 32-step divide (skipped when
// the ratio clamps to one), two 17-step square roots and 18 CORDIC steps,
// during which the input stall is held high. A zero-norm pair skips to the
// output step. A finished result keeps the input stalled until it is taken.
module fubini_study_angle
    import fsa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);
    localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
    localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
    localparam int PW = 2 * AccW;

    t_state r_state, n_state;
    logic signed [AccW-1:0] r_ire, r_iim, r_vn, r_wn;
    logic [CntW-1:0]        r_cnt;
    logic [PW:0]            r_n;
    logic [PW-1:0]          r_d;
    logic [1:0]             r_mstep;
    logic                   r_mstart;
    logic [PW:0]            r_rem;
    logic [32:0]            r_q;
    logic [5:0]             r_it;
    logic [33:0]            r_sx, r_sres;
    logic [17:0]            r_c, r_s;
    logic signed [19:0]     r_x, r_y;
    logic signed [ZW:0]     r_z;
    t_out_word              r_out;
    logic                   r_ovalid;

    logic [AccW-1:0] w_ma, w_mb;
    logic            w_mdone;
    logic [PW-1:0]   w_mp;
    logic in_fire;

    fsa_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mstart),
        .i_a(w_ma), .i_b(w_mb), .o_done(w_mdone), .o_p(w_mp)
    );

    function automatic logic signed [AccW-1:0] sat_add(
        input logic signed [AccW-1:0] a, input logic signed [33:0] d);
        logic signed [AccW:0] s;
        s = {a[AccW-1], a} + {{(AccW-33){d[33]}}, d};
        if (s > $signed({1'b0, AccMax})) sat_add = AccMax;
        else if (s < $signed({1'b1, AccMin})) sat_add = AccMin;
        else sat_add = s[AccW-1:0];
    endfunction

    function automatic logic [AccW-1:0] mag(input logic signed [AccW-1:0] v);
        mag = v[AccW-1] ? AccW'(-v) : v;
    endfunction

    // multiplier operand select by product index
    always_comb begin
        case (r_mstep)
            2'd0:    begin w_ma = mag(r_ire); w_mb = mag(r_ire); end
            2'd1:    begin w_ma = mag(r_iim); w_mb = mag(r_iim); end
            default: begin w_ma = r_vn;       w_mb = r_wn;       end
        endcase
    end

    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_ACC) || r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_ACC;
        else          r_state <= n_state;
    end

    // next-state logic; a zero norm skips straight to the output step
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_ACC:    if (in_fire && i_in_data.last) n_state = ST_MUL;
            ST_MUL:    if (r_vn == '0 || r_wn == '0) n_state = ST_OUT;
                       else if (w_mdone && r_mstep == 2'd2) n_state = ST_DIV;
            ST_DIV:    if (r_it == 6'd32) n_state = ST_SQRT_C;
            ST_SQRT_C: if (r_it == 6'd17) n_state = ST_SQRT_S;
            ST_SQRT_S: if (r_it == 6'd17) n_state = ST_CORDIC;
            ST_CORDIC: if (r_it == 6'(CordicN)) n_state = ST_OUT;
            ST_OUT:    n_state = ST_ACC;
            default:   n_state = ST_ACC;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        logic signed [33:0] d_re, d_im, d_v, d_w;
        logic signed [AccW-1:0] a_re, a_im, a_v, a_w;
        logic [PW:0] rs;
        logic [33:0] t;
        logic signed [19:0] dx, dy;
        if (!i_rst_n) begin
            r_ire <= '0; r_iim <= '0; r_vn <= '0; r_wn <= '0; r_cnt <= '0;
            r_ovalid <= 1'b0; r_mstart <= 1'b0; r_mstep <= '0; r_it <= '0;
        end else begin
            r_mstart <= 1'b0;
            if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_ACC: if (in_fire) begin
                    d_re = 34'(32'(i_in_data.v_real * i_in_data.w_real))
                         + 34'(32'(i_in_data.v_imag * i_in_data.w_imag));
                    d_im = 34'(32'(i_in_data.v_real * i_in_data.w_imag))
                         - 34'(32'(i_in_data.v_imag * i_in_data.w_real));
                    d_v  = 34'(32'(i_in_data.v_real * i_in_data.v_real))
                         + 34'(32'(i_in_data.v_imag * i_in_data.v_imag));
                    d_w  = 34'(32'(i_in_data.w_real * i_in_data.w_real))
                         + 34'(32'(i_in_data.w_imag * i_in_data.w_imag));
                    a_re = r_ire; a_im = r_iim; a_v = r_vn; a_w = r_wn;
                    if (r_cnt < CntW'(MaxLength)) begin
                        a_re = sat_add(r_ire, d_re); a_im = sat_add(r_iim, d_im);
                        a_v = sat_add(r_vn, d_v);    a_w = sat_add(r_wn, d_w);
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_ire <= a_re; r_iim <= a_im; r_vn <= a_v; r_wn <= a_w;
                    // start the products only when both norms are nonzero
                    if (i_in_data.last && a_v != '0 && a_w != '0) begin
                        r_mstep <= '0; r_mstart <= 1'b1; r_n <= '0;
                    end
                end
                ST_MUL: if (w_mdone) begin
                    if (r_mstep == 2'd2) begin
                        r_d <= w_mp; r_it <= '0; r_q <= '0;
                        r_rem <= r_n;
                    end else begin
                        r_n <= r_n + {1'b0, w_mp};
                        r_mstep <= r_mstep + 2'd1;
                        r_mstart <= 1'b1;
                    end
                end
                ST_DIV: begin
                    if (r_it == 6'd0 && r_rem >= {1'b0, r_d}) begin
                        r_q <= 33'h1_0000_0000; r_it <= 6'd32;
                    end else if (r_it == 6'd32) begin
                        r_it <= '0; r_sx <= {1'b0, r_q}; r_sres <= '0;
                    end else begin
                        rs = r_rem << 1;
                        if (rs >= {1'b0, r_d}) begin
                            r_rem <= rs - {1'b0, r_d};
                            r_q <= {r_q[31:0], 1'b1};
                        end else begin
                            r_rem <= rs; r_q <= {r_q[31:0], 1'b0};
                        end
                        r_it <= r_it + 6'd1;
                    end
                end
                ST_SQRT_C, ST_SQRT_S: begin
                    if (r_it == 6'd17) begin
                        r_it <= '0;
                        if (r_state == ST_SQRT_C) begin
                            r_c <= r_sres[17:0];
                            r_sx <= 34'h1_0000_0000 - {1'b0, r_q};
                            r_sres <= '0;
                        end else begin
                            r_s <= r_sres[17:0];
                            r_x <= {2'b0, r_c}; r_y <= {2'b0, r_sres[17:0]};
                            r_z <= '0;
                        end
                    end else begin
                        // bit = 4^(16 - it)
                        t = r_sres + (34'd1 << (6'd32 - {r_it[4:0], 1'b0}));
                        if (r_sx >= t) begin
                            r_sx <= r_sx - t;
                            r_sres <= (r_sres >> 1)
                                    + (34'd1 << (6'd32 - {r_it[4:0], 1'b0}));
                        end else begin
                            r_sres <= r_sres >> 1;
                        end
                        r_it <= r_it + 6'd1;
                    end
                end
                ST_CORDIC: if (r_it != 6'(CordicN)) begin
                    dx = r_y >>> r_it[4:0];
                    dy = r_x >>> r_it[4:0];
                    if (!r_y[19]) begin
                        r_x <= r_x + dx; r_y <= r_y - dy;
                        r_z <= r_z + $signed({1'b0, atan_q20(r_it[4:0])});
                    end else begin
                        r_x <= r_x - dx; r_y <= r_y + dy;
                        r_z <= r_z - $signed({1'b0, atan_q20(r_it[4:0])});
                    end
                    r_it <= r_it + 6'd1;
                end
                ST_OUT: begin
                    if (r_vn == '0 || r_wn == '0) begin
                        // zero norm: flag it with a zero angle
                        r_out.angle <= '0;
                        r_out.degenerate <= 1'b1;
                    end else begin
                        if (r_s == '0 || r_z[ZW]) r_out.angle <= '0;
                        else if (17'((r_z[ZW-1:0] + 22'd32) >> 6) > {1'b0, AngleMax})
                            r_out.angle <= AngleMax;
                        else r_out.angle <= 16'((r_z[ZW-1:0] + 22'd32) >> 6);
                        r_out.degenerate <= 1'b0;
                    end
                    r_ovalid <= 1'b1;
                    r_ire <= '0; r_iim <= '0; r_vn <= '0; r_wn <= '0; r_cnt <= '0;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped under stall");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_ACC |-> o_in_stall)
        else $error("input taken while busy");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(MaxLength))
        else $error("count beyond limit");
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.degenerate |-> o_out_data.angle == '0)
        else $error("degenerate with nonzero angle");
`endif
endmodule
